// ----- rtl/lbc_pkg.sv -----
// Shared constants and types of the LRU block cache read splitter.
package lbc_pkg;

    localparam int OFFSET_W   = 24;
    localparam int LENGTH_W   = 16;
    localparam int DLEN_W     = 25;
    localparam int STAMP_W    = 32;
    localparam int RES_CNT_W  = 6;
    localparam int SLOT_O_W   = 2;
    localparam int BLKNUM_O_W = 13;
    localparam int FILL_O_W   = 12;
    localparam int WITHIN_O_W = 11;
    localparam int COUNT_O_W  = 12;
    localparam int DEST_O_W   = 16;

    localparam logic [DLEN_W-1:0]    DATA_LENGTH_MAX = 25'd16777216;
    localparam logic [RES_CNT_W-1:0] MAX_RESULTS     = 6'd33;

    // One result item.
    typedef struct packed {
        logic [SLOT_O_W-1:0]   slot;
        logic                  hit;
        logic [BLKNUM_O_W-1:0] block_number;
        logic [FILL_O_W-1:0]   fill_size;
        logic [WITHIN_O_W-1:0] within_res;
        logic [COUNT_O_W-1:0]  count;
        logic [DEST_O_W-1:0]   dest_offset;
        logic                  error;
        logic                  last;
    } t_res;

    // Controller to datapath.
    typedef struct packed {
        logic load;        // capture request
        logic emit_short;  // error or empty result
        logic look;        // tag lookup, block geometry
        logic scan;        // one step of the oldest-stamp search
        logic emit;        // commit block, write result
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic range_err;
        logic empty;
        logic skip_scan;
        logic scan_done;
        logic out_free;
        logic last_blk;
    } t_sts;

endpackage

// ----- rtl/lbc_req_if.sv -----
// Request channel: offset and length of one read.
interface lbc_req_if;
    logic                           valid;
    logic                           ready;
    logic [lbc_pkg::OFFSET_W-1:0]   offset;
    logic [lbc_pkg::LENGTH_W-1:0]   length;

    modport source (output valid, offset, length, input ready);
    modport sink   (input valid, offset, length, output ready);
endinterface

// ----- rtl/lbc_res_if.sv -----
// Result channel: one item per block touched, or a single item for an error or empty request.
interface lbc_res_if;
    logic                             valid;
    logic                             ready;
    logic [lbc_pkg::SLOT_O_W-1:0]     slot;
    logic                             hit;
    logic [lbc_pkg::BLKNUM_O_W-1:0]   block_number;
    logic [lbc_pkg::FILL_O_W-1:0]     fill_size;
    logic [lbc_pkg::WITHIN_O_W-1:0]   within_res;
    logic [lbc_pkg::COUNT_O_W-1:0]    count;
    logic [lbc_pkg::DEST_O_W-1:0]     dest_offset;
    logic                             error;
    logic                             last;

    modport source (output valid, slot, hit, block_number, fill_size, within_res, count,
                    dest_offset, error, last, input ready);
    modport sink   (input valid, slot, hit, block_number, fill_size, within_res, count,
                    dest_offset, error, last, output ready);
endinterface

// ----- rtl/lru_block_cache_read_splitter.sv -----
// Top level of the LRU block cache read splitter.
//
//  channel  dir  handshake            payload
//  i_req    in   valid/ready          offset[23:0], length[15:0]
//  o_res    out  valid/ready          slot, hit, block_number, fill_size, within_res,
//                                     count, dest_offset, error, last
//  cfg      in   i_cfg_we, no ready   i_cfg_data[24:0] = data_length
//
// A request is taken only when the splitter is idle; in the next cycle the range
// check runs. Error and empty requests produce their single item from that check.
// On a miss the oldest-stamp search walks the stamp registers one slot per cycle;
// a hit, or a cache of a single slot, skips the search.
// Synchronous active-low reset; a data_length write clears all slots at once.
// A full result register with o_res.ready low holds the splitter in place; the
// next request is still taken while a finished item waits.
// BLOCK_BYTES must be a power of two (block math is shift and mask).
module lru_block_cache_read_splitter #(
    parameter int CACHE_SLOTS = 4,
    parameter int BLOCK_BYTES = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lbc_req_if.sink                       i_req,
    lbc_res_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [lbc_pkg::DLEN_W-1:0]    i_cfg_data
);

    lbc_pkg::t_cmd cmd;
    lbc_pkg::t_sts sts;
    lbc_pkg::t_res res;
    logic          res_valid;
    logic          req_ready;

    lbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lbc_dp #(
        .CACHE_SLOTS (CACHE_SLOTS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_offset    (i_req.offset),
        .i_length    (i_req.length),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_res_ready (o_res.ready),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    assign i_req.ready        = req_ready;

    // result register straight onto the channel
    assign o_res.valid        = res_valid;
    assign o_res.slot         = res.slot;
    assign o_res.hit          = res.hit;
    assign o_res.block_number = res.block_number;
    assign o_res.fill_size    = res.fill_size;
    assign o_res.within_res   = res.within_res;
    assign o_res.count        = res.count;
    assign o_res.dest_offset  = res.dest_offset;
    assign o_res.error        = res.error;
    assign o_res.last         = res.last;

endmodule

// ----- rtl/lbc_ctrl.sv -----
// Controller state machine of the read splitter.
module lbc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  lbc_pkg::t_sts i_sts,
    output lbc_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LOOK,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.range_err || i_sts.empty) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_short = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = i_sts.skip_scan ? S_EMIT : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.last_blk ? S_IDLE : S_LOOK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/lbc_dp.sv -----
// Datapath: slot tags, LRU stamps, block geometry and the result register.
module lbc_dp #(
    parameter int CACHE_SLOTS = 4,
    parameter int BLOCK_BYTES = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lbc_pkg::t_cmd                 i_cmd,
    output lbc_pkg::t_sts                 o_sts,
    input  logic [lbc_pkg::OFFSET_W-1:0]  i_offset,
    input  logic [lbc_pkg::LENGTH_W-1:0]  i_length,
    input  logic                          i_cfg_we,
    input  logic [lbc_pkg::DLEN_W-1:0]    i_cfg_data,
    input  logic                          i_res_ready,
    output lbc_pkg::t_res                 o_res,
    output logic                          o_res_valid
);

    localparam int OFS_W  = $clog2(BLOCK_BYTES);
    localparam int BN_W   = lbc_pkg::OFFSET_W - OFS_W;
    localparam int FILL_W = OFS_W + 1;
    localparam int SLOT_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CACHE_SLOTS - 1);
    localparam logic [FILL_W-1:0] BLK_SIZE  = FILL_W'(BLOCK_BYTES);

    // control state (reset)
    logic [lbc_pkg::DLEN_W-1:0]  r_dlen;
    logic [lbc_pkg::STAMP_W-1:0] r_use;
    logic [lbc_pkg::STAMP_W-1:0] r_stamp [CACHE_SLOTS];
    logic                        r_valid [CACHE_SLOTS];
    logic                        r_res_valid;

    // payload
    logic [BN_W-1:0]               r_tag [CACHE_SLOTS];
    logic [lbc_pkg::OFFSET_W-1:0]  r_at;
    logic [lbc_pkg::LENGTH_W-1:0]  r_left;
    logic [lbc_pkg::LENGTH_W-1:0]  r_copied;
    logic [lbc_pkg::RES_CNT_W-1:0] r_k;
    logic [OFS_W-1:0]              r_within;
    logic [FILL_W-1:0]             r_fill;
    logic                          r_hit;
    logic [SLOT_W-1:0]             r_sel;
    logic [SLOT_W-1:0]             r_scan;
    logic [lbc_pkg::STAMP_W-1:0]   r_best;
    lbc_pkg::t_res                 r_res;

    logic [BN_W-1:0]               blk;
    logic                          look_hit;
    logic [SLOT_W-1:0]             match_idx;
    logic [lbc_pkg::DLEN_W-1:0]    rem;
    logic [FILL_W-1:0]             fill;
    logic [FILL_W-1:0]             avail;
    logic [FILL_W-1:0]             n_cnt;
    logic [lbc_pkg::STAMP_W-1:0]   n_use;
    logic [lbc_pkg::STAMP_W-1:0]   scan_stamp;
    logic [lbc_pkg::DLEN_W-1:0]    req_end;
    logic                          out_free;
    logic                          last_blk;
    lbc_pkg::t_res                 short_res;

    assign blk = r_at[lbc_pkg::OFFSET_W-1:OFS_W];

    // parallel tag match, lowest matching slot wins
    always_comb begin
        look_hit  = 1'b0;
        match_idx = '0;
        for (int s = CACHE_SLOTS - 1; s >= 0; s--) begin
            if (r_valid[s] && (r_tag[s] == blk)) begin
                look_hit  = 1'b1;
                match_idx = SLOT_W'(s);
            end
        end
    end

    assign rem   = r_dlen - {1'b0, blk, {OFS_W{1'b0}}};
    assign fill  = (rem < lbc_pkg::DLEN_W'(BLOCK_BYTES)) ? rem[FILL_W-1:0] : BLK_SIZE;
    assign avail = r_fill - FILL_W'(r_within);
    assign n_cnt = (r_left < lbc_pkg::LENGTH_W'(avail)) ? r_left[FILL_W-1:0] : avail;
    assign n_use = r_use + 1'b1;
    assign scan_stamp = r_stamp[r_scan];
    assign req_end = {1'b0, r_at} + lbc_pkg::DLEN_W'(r_left);
    assign out_free = !r_res_valid || i_res_ready;
    assign last_blk = (r_left == lbc_pkg::LENGTH_W'(n_cnt))
                   || (r_k == (lbc_pkg::MAX_RESULTS - 1'b1));

    // error or empty item: all fields zero but error and last
    always_comb begin
        short_res       = '0;
        short_res.error = req_end > r_dlen;
        short_res.last  = 1'b1;
    end

    always_comb begin
        o_sts           = '0;
        o_sts.range_err = req_end > r_dlen;
        o_sts.empty     = r_left == '0;
        o_sts.skip_scan = look_hit || (CACHE_SLOTS == 1);
        o_sts.scan_done = r_scan == LAST_SLOT;
        o_sts.out_free  = out_free;
        o_sts.last_blk  = last_blk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dlen      <= '0;
            r_use       <= '0;
            r_res_valid <= 1'b0;
            for (int s = 0; s < CACHE_SLOTS; s++) begin
                r_stamp[s] <= '0;
                r_valid[s] <= 1'b0;
            end
        end else begin
            r_res_valid <= i_cmd.emit_short || i_cmd.emit || (r_res_valid && !i_res_ready);
            if (i_cfg_we) begin
                // saturate and drop the whole cache
                r_dlen <= (i_cfg_data > lbc_pkg::DATA_LENGTH_MAX) ?
                          lbc_pkg::DATA_LENGTH_MAX : i_cfg_data;
                r_use  <= '0;
                for (int s = 0; s < CACHE_SLOTS; s++) begin
                    r_stamp[s] <= '0;
                    r_valid[s] <= 1'b0;
                end
            end else if (i_cmd.emit) begin
                r_use          <= n_use;
                r_stamp[r_sel] <= n_use;
                r_valid[r_sel] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_at     <= i_offset;
            r_left   <= i_length;
            r_copied <= '0;
            r_k      <= '0;
        end
        if (i_cmd.emit_short) begin
            r_res <= short_res;
        end
        if (i_cmd.look) begin
            r_hit    <= look_hit;
            r_sel    <= look_hit ? match_idx : '0;
            r_best   <= r_stamp[0];
            r_scan   <= SLOT_W'(1);
            r_fill   <= fill;
            r_within <= r_at[OFS_W-1:0];
        end
        if (i_cmd.scan) begin
            if (scan_stamp < r_best) begin
                r_sel  <= r_scan;
                r_best <= scan_stamp;
            end
            r_scan <= r_scan + 1'b1;
        end
        if (i_cmd.emit) begin
            r_tag[r_sel]       <= blk;
            r_at               <= r_at + lbc_pkg::OFFSET_W'(n_cnt);
            r_left             <= r_left - lbc_pkg::LENGTH_W'(n_cnt);
            r_copied           <= r_copied + lbc_pkg::LENGTH_W'(n_cnt);
            r_k                <= r_k + 1'b1;
            r_res.slot         <= lbc_pkg::SLOT_O_W'(r_sel);
            r_res.hit          <= r_hit;
            r_res.block_number <= lbc_pkg::BLKNUM_O_W'(blk);
            r_res.fill_size    <= lbc_pkg::FILL_O_W'(r_fill);
            r_res.within_res   <= lbc_pkg::WITHIN_O_W'(r_within);
            r_res.count        <= lbc_pkg::COUNT_O_W'(n_cnt);
            r_res.dest_offset  <= r_copied;
            r_res.error        <= 1'b0;
            r_res.last         <= last_blk;
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule
